### hw/rtl/epcot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge pair crossing odds terms: shared package
// Widths, reset values and the stage control bundle of the block.
// ----------------------------------------------------------------------------
package epcot_pkg;

   localparam int NODE_BITS     = 14;
   localparam int POS_BITS_DEF  = 14;
   localparam int FIELD_BITS    = 14;
   localparam int TERM_BITS     = 30;
   localparam int DIFF_BITS     = 20;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int SUM_BITS      = PROD_BITS + 4;
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 64;

   localparam logic [NODE_BITS-1:0] NODE_COUNT_RESET = NODE_BITS'(2);
   localparam logic [TERM_BITS-1:0] TERM_MAX         = {TERM_BITS{1'b1}};

   typedef struct packed {
      logic load_s2;
      logic load_s3;
      logic load_s4;
      logic load_out;
   } stage_ctl_type;

endpackage

### hw/rtl/epcot_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge pair crossing odds terms: arithmetic pipeline
// Orders the two lengths, forms the products in parallel, adds the branch
// terms and clamps the results to the output width.
// ----------------------------------------------------------------------------
module epcot_core
   import epcot_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic                 clock,
   input  stage_ctl_type        ctl,
   input  logic [POS_BITS-1:0]  len_a,
   input  logic [POS_BITS-1:0]  len_b,
   input  logic [NODE_BITS-1:0] node_count,
   output logic [TERM_BITS-1:0] alpha_term,
   output logic [TERM_BITS-1:0] beta_term
);

   localparam int DW = DIFF_BITS;
   localparam int PW = PROD_BITS;
   localparam int SW = SUM_BITS;

   // Stage 2: ordered lengths, linear operands and branch flags.
   logic [POS_BITS-1:0] d1_u;
   logic [POS_BITS-1:0] d2_u;
   logic signed [DW-1:0] d1_s, d2_s, n_s, sum_s, smn_s;
   logic signed [DW-1:0] d1_ff, d2_ff, n_ff, d1m1_ff, d1m1_in, nms_ff, nms_in;
   logic signed [DW-1:0] x_ff, x_in, xp1_ff, xp1_in, nmd1_ff, nmd1_in;
   logic signed [DW-1:0] q4b_ff, q4b_in, q5b_ff, q5b_in, nm3_ff, nm3_in;
   logic signed [DW-1:0] q7b_ff, q7b_in, lin1_ff, lin1_in, lin2_ff, lin2_in;
   logic c1_ff, c1_in, c0_ff, c0_in, eq_ff, eq_in;

   always_comb begin
      if (len_a <= len_b) begin
         d1_u = len_a;
         d2_u = len_b;
      end else begin
         d1_u = len_b;
         d2_u = len_a;
      end
      d1_s    = $signed({{(DW-POS_BITS){1'b0}}, d1_u});
      d2_s    = $signed({{(DW-POS_BITS){1'b0}}, d2_u});
      n_s     = $signed({{(DW-NODE_BITS){1'b0}}, node_count});
      sum_s   = d1_s + d2_s;
      smn_s   = sum_s - n_s;
      d1m1_in = d1_s - DW'(1);
      nms_in  = n_s - sum_s;
      x_in    = d2_s - n_s;
      xp1_in  = d2_s - n_s + DW'(1);
      nmd1_in = n_s - d1_s;
      q4b_in  = (d2_s <<< 1) - d1_s - DW'(3);
      q5b_in  = (d1_s <<< 1) - d2_s - n_s + DW'(3);
      nm3_in  = n_s - DW'(3);
      q7b_in  = DW'(6) - (n_s <<< 1);
      lin1_in = (smn_s <<< 1) + smn_s - d1_s;
      lin2_in = (smn_s <<< 2) + smn_s;
      c1_in   = (nms_in > DW'(0));
      c0_in   = !nms_in[DW-1];
      eq_in   = (d1_u == d2_u);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         d1_ff   <= d1_s;
         d2_ff   <= d2_s;
         n_ff    <= n_s;
         d1m1_ff <= d1m1_in;
         nms_ff  <= nms_in;
         x_ff    <= x_in;
         xp1_ff  <= xp1_in;
         nmd1_ff <= nmd1_in;
         q4b_ff  <= q4b_in;
         q5b_ff  <= q5b_in;
         nm3_ff  <= nm3_in;
         q7b_ff  <= q7b_in;
         lin1_ff <= lin1_in;
         lin2_ff <= lin2_in;
         c1_ff   <= c1_in;
         c0_ff   <= c0_in;
         eq_ff   <= eq_in;
      end
   end

   // Stage 3: independent products.
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff, q1_ff, q2_ff, q3_ff;
   logic signed [PW-1:0] q4_ff, q5_ff, q6_ff, q7_ff;
   logic signed [DW-1:0] lin1_s3_ff, lin2_s3_ff;
   logic c1_s3_ff, c0_s3_ff, eq_s3_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_s3) begin
         p1_ff      <= PW'(d1m1_ff) * PW'(nms_ff);
         p2_ff      <= PW'(d1_ff) * PW'(d1m1_ff);
         p3_ff      <= PW'(x_ff) * PW'(xp1_ff);
         q1_ff      <= PW'(x_ff) * PW'(x_ff);
         q2_ff      <= PW'(nmd1_ff) * PW'(nmd1_ff);
         q3_ff      <= PW'(d2_ff) * PW'(d2_ff);
         q4_ff      <= PW'(d1_ff) * PW'(q4b_ff);
         q5_ff      <= PW'(x_ff) * PW'(q5b_ff);
         q6_ff      <= PW'(n_ff) * PW'(nm3_ff);
         q7_ff      <= PW'(d1_ff) * PW'(q7b_ff);
         lin1_s3_ff <= lin1_ff;
         lin2_s3_ff <= lin2_ff;
         c1_s3_ff   <= c1_ff;
         c0_s3_ff   <= c0_ff;
         eq_s3_ff   <= eq_ff;
      end
   end

   // Stage 4: branch selection and partial sums.
   logic signed [SW-1:0] alpha_ff, alpha_in, beta_a_ff, beta_a_in, beta_b_ff, beta_b_in;
   logic signed [SW-1:0] tail_c1, tail_c0;

   always_comb begin
      if (c1_s3_ff) begin
         alpha_in  = (SW'(p1_ff) <<< 1) + SW'(p2_ff);
         beta_a_in = SW'(q1_ff) + SW'(lin1_s3_ff);
      end else begin
         alpha_in  = SW'(p3_ff);
         beta_a_in = SW'(p3_ff);
      end
      if (eq_s3_ff) begin
         tail_c1 = c1_s3_ff ? SW'(q6_ff) + SW'(q7_ff) : SW'(0);
         tail_c0 = c0_s3_ff ? SW'(p2_ff) : SW'(p3_ff);
      end else begin
         tail_c1 = c1_s3_ff ? SW'(q2_ff) + SW'(lin2_s3_ff) - SW'(q3_ff) : SW'(0);
         tail_c0 = c0_s3_ff ? SW'(q4_ff) : SW'(q5_ff);
      end
      beta_b_in = tail_c1 + tail_c0;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s4) begin
         alpha_ff  <= alpha_in;
         beta_a_ff <= beta_a_in;
         beta_b_ff <= beta_b_in;
      end
   end

   // Stage 5: final add, halving of beta and clamping.
   logic signed [SW-1:0] beta_sum, beta_half;
   logic [TERM_BITS-1:0] alpha_out_ff, alpha_out_in, beta_out_ff, beta_out_in;

   always_comb begin
      beta_sum  = beta_a_ff + beta_b_ff;
      beta_half = beta_sum >>> 1;
      if (alpha_ff[SW-1]) begin
         alpha_out_in = '0;
      end else if (alpha_ff > $signed({{(SW-TERM_BITS){1'b0}}, TERM_MAX})) begin
         alpha_out_in = TERM_MAX;
      end else begin
         alpha_out_in = alpha_ff[TERM_BITS-1:0];
      end
      if (beta_sum[SW-1]) begin
         beta_out_in = '0;
      end else if (beta_half > $signed({{(SW-TERM_BITS){1'b0}}, TERM_MAX})) begin
         beta_out_in = TERM_MAX;
      end else begin
         beta_out_in = beta_half[TERM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         alpha_out_ff <= alpha_out_in;
         beta_out_ff  <= beta_out_in;
      end
   end

   assign alpha_term = alpha_out_ff;
   assign beta_term  = beta_out_ff;

endmodule

### hw/rtl/edge_pair_crossing_odds_terms_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge pair crossing odds terms unit
// Takes the endpoint positions of two independent edges and returns the
// alpha and beta terms for the node count held in its register.
//
// Items enter on the req_ channel and leave on the rsp_ channel; both are
// valid/ready streams. Each request item carries four positions and yields
// exactly one response item with alpha and beta.
// The node count is written through the csr_ channel, which is always ready.
// It should be written only while no item is in flight.
// A request item can be accepted in every cycle unless a receiver stall has
// backed the pipeline up to its input. The five stages are the length
// subtraction, operand forming, the multipliers, the branch sums, and the
// final add with clamping into the output register.
// Each stage has its own valid bit and holds only while the stage after it
// is full and held, so bubbles close up while the receiver stalls and
// nothing is lost or repeated.
// Reset empties the pipeline and sets the node count to 2.
// ----------------------------------------------------------------------------
module edge_pair_crossing_odds_terms_unit
   import epcot_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // pos_first_a, pos_first_b, pos_second_a, pos_second_b
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // alpha_term, beta_term, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [NODE_BITS-1:0]     csr_data
);

   logic [NODE_BITS-1:0] node_count_ff, node_count_in;

   assign csr_ready     = 1'b1;
   assign node_count_in = (csr_valid && csr_ready) ? csr_data : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   logic [4:0] valid_ff, valid_in;
   logic [4:0] load;

   always_comb begin
      load[4] = !valid_ff[4] || rsp_tready;
      load[3] = !valid_ff[3] || load[4];
      load[2] = !valid_ff[2] || load[3];
      load[1] = !valid_ff[1] || load[2];
      load[0] = !valid_ff[0] || load[1];
      valid_in[0] = load[0] ? req_tvalid : valid_ff[0];
      valid_in[1] = load[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = load[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = load[3] ? valid_ff[2] : valid_ff[3];
      valid_in[4] = load[4] ? valid_ff[3] : valid_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = load[0];
   assign rsp_tvalid = valid_ff[4];

   logic [POS_BITS-1:0] pos_fa, pos_fb, pos_sa, pos_sb;
   logic [POS_BITS-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;

   always_comb begin
      pos_fa   = req_tdata[POS_BITS-1:0];
      pos_fb   = req_tdata[FIELD_BITS +: POS_BITS];
      pos_sa   = req_tdata[2*FIELD_BITS +: POS_BITS];
      pos_sb   = req_tdata[3*FIELD_BITS +: POS_BITS];
      len_a_in = (pos_fa < pos_fb) ? pos_fb - pos_fa : pos_fa - pos_fb;
      len_b_in = (pos_sa < pos_sb) ? pos_sb - pos_sa : pos_sa - pos_sb;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         len_a_ff <= len_a_in;
         len_b_ff <= len_b_in;
      end
   end

   stage_ctl_type        ctl;
   logic [TERM_BITS-1:0] alpha_term;
   logic [TERM_BITS-1:0] beta_term;

   assign ctl.load_s2  = load[1];
   assign ctl.load_s3  = load[2];
   assign ctl.load_s4  = load[3];
   assign ctl.load_out = load[4];

   epcot_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock      (clock),
      .ctl        (ctl),
      .len_a      (len_a_ff),
      .len_b      (len_b_ff),
      .node_count (node_count_ff),
      .alpha_term (alpha_term),
      .beta_term  (beta_term)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS-2*TERM_BITS){1'b0}}, beta_term, alpha_term};

endmodule

### bench/tb_edge_pair_crossing_odds_terms_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the edge pair crossing odds terms unit
// Sends edge pairs over the request stream under several node counts and
// predicts alpha and beta for each accepted item. Each response item is
// compared with the oldest prediction. Both streams idle and stall at random,
// and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_edge_pair_crossing_odds_terms_unit;
   import epcot_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int POS_MAX      = (1 << FIELD_BITS) - 1;

   typedef logic [FIELD_BITS-1:0] pos_type;

   typedef struct packed {
      pos_type second_b;
      pos_type second_a;
      pos_type first_b;
      pos_type first_a;
   } edge_pair_type;

   typedef struct packed {
      logic [TERM_BITS-1:0] beta;
      logic [TERM_BITS-1:0] alpha;
   } odds_terms_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // pos_first_a, pos_first_b, pos_second_a, pos_second_b
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // alpha_term, beta_term, zero fill
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [NODE_BITS-1:0]     csr_data   = '0;

   logic [NODE_BITS-1:0] node_count_model = NODE_COUNT_RESET;
   odds_terms_type       pending_terms[$];
   int                   error_count   = 0;
   int                   cycle_count   = 0;
   bit                   tx_gaps_on    = 1'b0;
   bit                   rx_stalls_on  = 1'b0;
   int                   hold_asked    = 0;
   int                   hold_taken    = 0;
   int                   rx_stall_left = 0;

   edge_pair_crossing_odds_terms_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint alpha_count(longint n, longint d1, longint d2);
      longint f;
      f = 0;
      if (1 <= n - (d1 + d2)) begin
         f += (d1 - 1) * (n - d2 - d1);
         f += (d1 * (d1 - 1)) / 2;
      end else begin
         f += ((d2 - n) * (d2 - n + 1)) / 2;
      end
      if (d1 + d2 <= n) begin
         f += (d1 - 1) * (n - d2 - d1);
      end
      if (d2 >= d1) begin
         if (1 + d2 <= n - d1) begin
            f += (d1 * (d1 - 1)) / 2;
         end else begin
            f += ((n - d2) * (n - d2 - 1)) / 2;
         end
      end
      return f;
   endfunction

   function automatic longint beta_count(longint n, longint d1, longint d2);
      longint f;
      f = 0;
      if (1 <= n - (d1 + d2)) begin
         f += (n - d2) * (n - d2) + 3 * (d1 + d2 - n) - d1 * d1;
         f += d1 * (d1 - 1);
      end else begin
         f += (d2 - n) * (d2 - n + 1);
      end
      if (d1 < d2) begin
         if (1 + d2 <= n - d1) begin
            f += (n - d1) * (n - d1) - 5 * (n - d1 - d2) - d2 * d2;
         end
         if (d2 <= n - d1) begin
            f += d1 * (2 * d2 - d1 - 3);
         end else begin
            f += (d2 - n) * (2 * d1 - d2 - n + 3);
         end
      end else begin
         if (1 + 2 * d1 <= n) begin
            f += n * (n - 3) + d1 * (6 - 2 * n);
         end
         if (2 * d1 <= n) begin
            f += d1 * (d1 - 1);
         end else begin
            f += (d1 - n) * (d1 - n + 1);
         end
      end
      return f / 2;
   endfunction

   function automatic logic [TERM_BITS-1:0] clamp_term(longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > longint'(TERM_MAX)) begin
         return TERM_MAX;
      end
      return v[TERM_BITS-1:0];
   endfunction

   function automatic odds_terms_type predict_odds_terms(edge_pair_type pair);
      longint         n;
      longint         len_first;
      longint         len_second;
      longint         d1;
      longint         d2;
      odds_terms_type terms;
      n          = longint'(node_count_model);
      len_first  = longint'(pair.first_a) - longint'(pair.first_b);
      len_second = longint'(pair.second_a) - longint'(pair.second_b);
      if (len_first < 0) begin
         len_first = -len_first;
      end
      if (len_second < 0) begin
         len_second = -len_second;
      end
      d1          = (len_first <= len_second) ? len_first : len_second;
      d2          = (len_first <= len_second) ? len_second : len_first;
      terms.alpha = clamp_term(alpha_count(n, d1, d2));
      terms.beta  = clamp_term(beta_count(n, d1, d2));
      return terms;
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   function automatic edge_pair_type pair_of(int fa, int fb, int sa, int sb);
      edge_pair_type pair;
      pair.first_a  = pos_type'(fa);
      pair.first_b  = pos_type'(fb);
      pair.second_a = pos_type'(sa);
      pair.second_b = pos_type'(sb);
      return pair;
   endfunction

   // Mostly endpoints inside the arrangement, some pairs of equal length, and
   // some positions anywhere in the field range.
   function automatic edge_pair_type random_edge_pair(int n);
      int r;
      int top;
      int len;
      int fa;
      int sa;
      r   = $urandom_range(0, 99);
      top = (n >= 2) ? n - 1 : 1;
      if (r < 15) begin
         return pair_of($urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX),
                        $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX));
      end else if (r < 35) begin
         len = $urandom_range(0, top);
         fa  = $urandom_range(0, top - len);
         sa  = $urandom_range(0, top - len);
         if ($urandom_range(0, 1) == 1) begin
            return pair_of(fa + len, fa, sa, sa + len);
         end
         return pair_of(fa, fa + len, sa + len, sa);
      end
      return pair_of($urandom_range(0, top), $urandom_range(0, top),
                     $urandom_range(0, top), $urandom_range(0, top));
   endfunction

   task automatic send_edge_pair(input edge_pair_type pair);
      int gap;
      gap = tx_gaps_on ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pair;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_terms.push_back(predict_odds_terms(pair));
   endtask

   task automatic wait_all_terms();
      req_tvalid <= 1'b0;
      while (pending_terms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [NODE_BITS-1:0] value);
      wait_all_terms();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid        <= 1'b0;
      node_count_model = value;
   endtask

   task automatic test_reset_node_count();
      send_edge_pair(pair_of(0, 1, 0, 1));
      send_edge_pair(pair_of(0, 0, 0, 0));
      send_edge_pair(pair_of(POS_MAX, 0, 0, POS_MAX));
   endtask

   task automatic test_field_extremes();
      write_node_count(NODE_BITS'(POS_MAX));
      send_edge_pair(pair_of(0, 0, 0, 0));
      send_edge_pair(pair_of(POS_MAX, POS_MAX, POS_MAX, POS_MAX));
      send_edge_pair(pair_of(0, POS_MAX, POS_MAX, 0));
      send_edge_pair(pair_of(0, POS_MAX - 1, 1, 2));
      send_edge_pair(pair_of(0, 1, 2, 3));
      send_edge_pair(pair_of(5, 9, 100, 104));
      send_edge_pair(pair_of(0, 8191, 8192, POS_MAX));
      send_edge_pair(pair_of(POS_MAX, 0, 1, 2));
      send_edge_pair(pair_of(10922, 5461, 0, 5461));
   endtask

   task automatic test_small_node_counts();
      write_node_count(NODE_BITS'(0));
      send_edge_pair(pair_of(0, 1, 2, 3));
      send_edge_pair(pair_of(3, 0, 0, 0));
      write_node_count(NODE_BITS'(1));
      send_edge_pair(pair_of(0, 1, 0, 0));
      send_edge_pair(pair_of(0, 0, 0, 0));
      write_node_count(NODE_BITS'(3));
      send_edge_pair(pair_of(0, 2, 1, 1));
      send_edge_pair(pair_of(0, 1, 1, 2));
      send_edge_pair(pair_of(2, 0, 0, 2));
      write_node_count(NODE_BITS'(4));
      send_edge_pair(pair_of(0, 1, 2, 3));
   endtask

   task automatic test_backpressure();
      write_node_count(NODE_BITS'(500));
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      hold_asked++;
      for (int i = 0; i < 40; i++) begin
         send_edge_pair(random_edge_pair(500));
      end
      wait_all_terms();
   endtask

   task automatic test_random_pairs();
      int n;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: n = POS_MAX;
            1: n = 2;
            2: n = 5;
            default: n = (phase % 2 == 1) ? $urandom_range(6, 60)
                                          : $urandom_range(61, POS_MAX);
         endcase
         tx_gaps_on   = (phase % 3 != 0);
         rx_stalls_on = (phase % 4 != 1);
         write_node_count(NODE_BITS'(n));
         for (int i = 0; i < 100; i++) begin
            if (i == 50) begin
               wait_all_terms();
            end
            send_edge_pair(random_edge_pair(n));
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken    = hold_asked;
         rx_stall_left = HOLD_CYCLES;
      end
      if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
         rx_stall_left = idle_length();
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      odds_terms_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_terms.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response item, expected none, actual %h", $time,
                     rsp_tdata);
         end else begin
            want = pending_terms.pop_front();
            if (rsp_tdata[TERM_BITS-1:0] !== want.alpha) begin
               error_count++;
               $display("%0t: alpha_term mismatch, expected %0d, actual %0d", $time,
                        want.alpha, rsp_tdata[TERM_BITS-1:0]);
            end
            if (rsp_tdata[2*TERM_BITS-1:TERM_BITS] !== want.beta) begin
               error_count++;
               $display("%0t: beta_term mismatch, expected %0d, actual %0d", $time,
                        want.beta, rsp_tdata[2*TERM_BITS-1:TERM_BITS]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items outstanding", $time, pending_terms.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_node_count();
      test_field_extremes();
      test_small_node_counts();
      test_backpressure();
      test_random_pairs();
      wait_all_terms();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
